FILE: rtl/avcc_to_annexb_with_idr_detect_defines.svh
// ----------------------------------------------------------------------------
// avcc_to_annexb_with_idr_detect assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef AVCC_TO_ANNEXB_WITH_IDR_DETECT_DEFINES_SVH
`define AVCC_TO_ANNEXB_WITH_IDR_DETECT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define A2B_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("a2b port check failed");

// next-cycle implication, disabled during reset
`define A2B_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("a2b port check failed");

`endif

FILE: rtl/a2b_pkg.sv
// ----------------------------------------------------------------------------
// a2b_pkg
// types, sizes and constants of the length-prefix to start-code converter
// ----------------------------------------------------------------------------
`default_nettype none

package a2b_pkg;

   localparam int MAX_FRAME_BYTES = 65536;
   localparam int ADDR_W          = $clog2(MAX_FRAME_BYTES);
   localparam int COUNT_W         = ADDR_W + 1;
   localparam int NHA_W           = 33;
   // frame byte plus header mark and last header byte flag
   localparam int RAM_W           = 10;

   localparam logic       KIND_LOAD  = 1'b0;
   localparam logic       KIND_FETCH = 1'b1;

   localparam logic [7:0]  NAL_TYPE_MASK = 8'h1f;
   localparam logic [7:0]  IDR_TYPE      = 8'd5;
   localparam logic [31:0] START_CODE4   = 32'h0000_0001;
   localparam logic [23:0] START_CODE3   = 24'h00_0001;

   typedef enum logic [0:0] {
      PHASE_LOAD,
      PHASE_EMIT
   } phase_type;

   typedef struct packed {
      logic found;
      logic pending;
   } idr_scan_type;

   // one step of the idr search over a byte window
   function automatic idr_scan_type idr_scan(
      input logic [31:0]  win,
      input logic [7:0]   b,
      input logic         past3,
      input logic         past4,
      input idr_scan_type cur
   );
      idr_scan_type r;
      r = cur;
      if (cur.pending) begin
         r.found   = 1'b1;
         r.pending = 1'b0;
      end
      if ((b & NAL_TYPE_MASK) == IDR_TYPE) begin
         if (past4 && win == START_CODE4) begin
            r.found = 1'b1;
         end else if (past3 && win[23:0] == START_CODE3) begin
            r.pending = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/avcc_to_annexb_with_idr_detect.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_with_idr_detect
// load beats give no result; a fetch beat gives its result beat through the
// frame ram read register and then the output register
// one beat per cycle sustained while the result side keeps up
// synchronous reset returns to loading an empty frame; the frame ram holds
// no reset state and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_with_idr_detect
   import a2b_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte
   input  wire logic       req_tuser,   // kind
   input  wire logic       req_tlast,   // last_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata,   // out_byte
   output logic      [2:0] rsp_tuser,   // overflowed, was_converted, has_idr
   output logic            rsp_tlast    // out_last
);

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   frame_count_ff, frame_count_in;
   logic [NHA_W-1:0]     next_header_at_ff, next_header_at_in;
   logic [31:0]          length_accum_ff, length_accum_in;
   logic                 chain_failed_ff, chain_failed_in;
   logic [31:0]          raw_window_ff, raw_window_in;
   logic [31:0]          conv_window_ff, conv_window_in;
   idr_scan_type         idr_raw_ff, idr_raw_in;
   idr_scan_type         idr_conv_ff, idr_conv_in;
   logic [COUNT_W-1:0]   emit_pointer_ff, emit_pointer_in;
   logic                 overflow_ff, overflow_in;
   logic                 conv_flag_ff, conv_flag_in;
   logic                 idr_final_ff, idr_final_in;
   logic [31:0]          head_ff, head_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_idr_ff, s1_idr_in;
   logic                 s1_conv_ff, s1_conv_in;
   logic                 s1_ovf_ff, s1_ovf_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [2:0]           rsp_user_ff, rsp_user_in;

   logic                 accept;
   logic                 load_ok;
   logic                 store;
   logic                 fetch_ok;
   logic                 s1_move;
   logic [NHA_W-1:0]     pos_ext;
   logic                 is_hdr;
   logic [1:0]           hdr_k;
   logic [31:0]          accum_shift;
   logic [7:0]           conv_byte;
   logic [COUNT_W-1:0]   emit_plus;
   logic                 fin;
   logic                 start_code;
   logic [RAM_W-1:0]     ram_wr_data;
   logic [RAM_W-1:0]     ram_rd_data;

   assign accept   = req_tvalid && req_tready;
   assign load_ok  = accept && req_tuser == KIND_LOAD && phase_ff == PHASE_LOAD;
   assign store    = load_ok && frame_count_ff < COUNT_W'(MAX_FRAME_BYTES);
   assign emit_plus = emit_pointer_ff + 1'b1;
   assign fetch_ok = accept && req_tuser == KIND_FETCH && phase_ff == PHASE_EMIT &&
                     emit_pointer_ff < frame_count_ff;
   assign fin      = emit_plus >= frame_count_ff;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;

   assign pos_ext     = NHA_W'(frame_count_ff);
   assign is_hdr      = !chain_failed_ff && pos_ext >= next_header_at_ff;
   assign hdr_k       = frame_count_ff[1:0] - next_header_at_ff[1:0];
   assign accum_shift = {length_accum_ff[23:0], req_tdata};
   assign conv_byte   = is_hdr ? {7'd0, hdr_k == 2'd3} : req_tdata;
   assign ram_wr_data = {is_hdr, hdr_k == 2'd3, req_tdata};

   a2b_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (frame_count_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (fetch_ok),
      .rd_addr (emit_pointer_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      phase_in          = phase_ff;
      frame_count_in    = frame_count_ff;
      next_header_at_in = next_header_at_ff;
      length_accum_in   = length_accum_ff;
      chain_failed_in   = chain_failed_ff;
      raw_window_in     = raw_window_ff;
      conv_window_in    = conv_window_ff;
      idr_raw_in        = idr_raw_ff;
      idr_conv_in       = idr_conv_ff;
      emit_pointer_in   = emit_pointer_ff;
      overflow_in       = overflow_ff;
      conv_flag_in      = conv_flag_ff;
      idr_final_in      = idr_final_ff;
      head_in           = head_ff;
      start_code        = 1'b0;

      // load side
      if (store) begin
         if (is_hdr) begin
            length_accum_in = (hdr_k == 2'd0) ? {24'd0, req_tdata} : accum_shift;
            if (hdr_k == 2'd3) begin
               if (accum_shift == 32'd0) begin
                  chain_failed_in = 1'b1;
               end else begin
                  next_header_at_in = pos_ext + NHA_W'(1) + NHA_W'(accum_shift);
               end
            end
         end
         idr_raw_in  = idr_scan(raw_window_ff, req_tdata, frame_count_ff >= COUNT_W'(3),
                                frame_count_ff >= COUNT_W'(4), idr_raw_ff);
         idr_conv_in = idr_scan(conv_window_ff, conv_byte, frame_count_ff >= COUNT_W'(3),
                                frame_count_ff >= COUNT_W'(4), idr_conv_ff);
         raw_window_in  = {raw_window_ff[23:0], req_tdata};
         conv_window_in = {conv_window_ff[23:0], conv_byte};
         if (frame_count_ff < COUNT_W'(4)) begin
            head_in = {raw_window_ff[23:0], req_tdata};
         end
         frame_count_in = frame_count_ff + 1'b1;
      end else if (load_ok) begin
         overflow_in = 1'b1;
      end

      // end of frame decision
      if (load_ok && req_tlast) begin
         start_code = head_in[31:24] == 8'd0 && head_in[23:16] == 8'd0 &&
                      (head_in[15:8] == 8'd1 ||
                       (head_in[15:8] == 8'd0 && head_in[7:0] == 8'd1));
         conv_flag_in = !overflow_in && frame_count_in >= COUNT_W'(4) && !start_code &&
                        !chain_failed_in && next_header_at_in == NHA_W'(frame_count_in);
         idr_final_in    = conv_flag_in ? idr_conv_in.found : idr_raw_in.found;
         emit_pointer_in = '0;
         phase_in        = PHASE_EMIT;
      end

      // fetch side
      if (fetch_ok) begin
         emit_pointer_in = emit_plus;
         if (fin) begin
            phase_in          = PHASE_LOAD;
            frame_count_in    = '0;
            next_header_at_in = '0;
            length_accum_in   = '0;
            chain_failed_in   = 1'b0;
            raw_window_in     = '0;
            conv_window_in    = '0;
            idr_raw_in        = '0;
            idr_conv_in       = '0;
            emit_pointer_in   = '0;
            overflow_in       = 1'b0;
            conv_flag_in      = 1'b0;
            idr_final_in      = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      s1_idr_in   = s1_idr_ff;
      s1_conv_in  = s1_conv_ff;
      s1_ovf_in   = s1_ovf_ff;
      if (fetch_ok) begin
         s1_valid_in = 1'b1;
         s1_last_in  = fin;
         s1_idr_in   = fin && idr_final_ff;
         s1_conv_in  = conv_flag_ff;
         s1_ovf_in   = overflow_ff;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (s1_conv_ff && ram_rd_data[9]) ? {7'd0, ram_rd_data[8]}
                                                       : ram_rd_data[7:0];
         rsp_last_in  = s1_last_ff;
         rsp_user_in  = {s1_ovf_ff, s1_conv_ff, s1_idr_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PHASE_LOAD;
         frame_count_ff    <= '0;
         next_header_at_ff <= '0;
         length_accum_ff   <= '0;
         chain_failed_ff   <= 1'b0;
         raw_window_ff     <= '0;
         conv_window_ff    <= '0;
         idr_raw_ff        <= '0;
         idr_conv_ff       <= '0;
         emit_pointer_ff   <= '0;
         overflow_ff       <= 1'b0;
         conv_flag_ff      <= 1'b0;
         idr_final_ff      <= 1'b0;
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         frame_count_ff    <= frame_count_in;
         next_header_at_ff <= next_header_at_in;
         length_accum_ff   <= length_accum_in;
         chain_failed_ff   <= chain_failed_in;
         raw_window_ff     <= raw_window_in;
         conv_window_ff    <= conv_window_in;
         idr_raw_ff        <= idr_raw_in;
         idr_conv_ff       <= idr_conv_in;
         emit_pointer_ff   <= emit_pointer_in;
         overflow_ff       <= overflow_in;
         conv_flag_ff      <= conv_flag_in;
         idr_final_ff      <= idr_final_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      s1_last_ff  <= s1_last_in;
      s1_idr_ff   <= s1_idr_in;
      s1_conv_ff  <= s1_conv_in;
      s1_ovf_ff   <= s1_ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: rtl/a2b_ram.sv
// ----------------------------------------------------------------------------
// a2b_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/a2b_checker.sv
// ----------------------------------------------------------------------------
// a2b_checker
// port-level checks of the converter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "avcc_to_annexb_with_idr_detect_defines.svh"

module a2b_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       req_tuser,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // a stalled result beat holds
   `A2B_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // idr flag only on the closing beat of a frame
   `A2B_ASSERT_IMP(a_idr_on_last, rsp_tvalid && !rsp_tlast, !rsp_tuser[0])

   // an overflowed frame is never converted
   `A2B_ASSERT_IMP(a_ovf_no_conv, rsp_tvalid && rsp_tuser[2], !rsp_tuser[1])

   // a fresh result beat comes from an accepted fetch beat, through the ram read and output registers
   `A2B_ASSERT_IMP(a_rsp_from_fetch, $rose(rsp_tvalid), $past(req_tvalid && req_tready && req_tuser, 2))

endmodule

bind avcc_to_annexb_with_idr_detect a2b_checker u_a2b_checker (.*);

`default_nettype wire
